// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/ipv4hrc_pkg.sv =====
// ---------------------------------------------------------------------------
// ipv4hrc_pkg
// Types and constants for the IPv4 header receive check.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv4hrc_pkg;

   // verdict codes
   typedef enum logic [2:0] {
      VERDICT_ICMP          = 3'd0,
      VERDICT_UDP           = 3'd1,
      VERDICT_TCP           = 3'd2,
      VERDICT_MALFORMED     = 3'd3,
      VERDICT_FRAGMENT      = 3'd4,
      VERDICT_NOT_FOR_HOST  = 3'd5,
      VERDICT_PROTO_UNSUPP  = 3'd6
   } verdict_type;

   // csr register indexes
   localparam logic CSR_HOST_ADDRESS = 1'b0;
   localparam logic CSR_SUBNET_MASK  = 1'b1;

   // header byte offsets
   localparam logic [15:0] OFS_VERSION_IHL = 16'd0;
   localparam logic [15:0] OFS_TOTAL_HI    = 16'd2;
   localparam logic [15:0] OFS_TOTAL_LO    = 16'd3;
   localparam logic [15:0] OFS_FRAG_HI     = 16'd6;
   localparam logic [15:0] OFS_FRAG_LO     = 16'd7;
   localparam logic [15:0] OFS_TTL         = 16'd8;
   localparam logic [15:0] OFS_PROTOCOL    = 16'd9;
   localparam logic [15:0] OFS_SRC_FIRST   = 16'd12;
   localparam logic [15:0] OFS_SRC_LAST    = 16'd15;
   localparam logic [15:0] OFS_DST_FIRST   = 16'd16;
   localparam logic [15:0] OFS_DST_LAST    = 16'd19;

   localparam logic [15:0] COUNT_MAX        = 16'hffff;
   localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
   localparam logic [3:0]  IPV4_VERSION     = 4'd4;
   localparam logic [15:0] FRAG_MASK        = 16'h3fff;
   localparam logic [15:0] SUM_GOOD         = 16'hffff;
   localparam logic [31:0] LIMITED_BCAST    = 32'hffff_ffff;
   localparam logic [7:0]  PROTO_ICMP       = 8'd1;
   localparam logic [7:0]  PROTO_TCP        = 8'd6;
   localparam logic [7:0]  PROTO_UDP        = 8'd17;

   // per-packet header state as seen after the current byte
   typedef struct packed {
      logic [15:0] byte_count;
      logic [3:0]  header_words;
      logic [3:0]  version;
      logic [15:0] sum;
      logic [15:0] total_length;
      logic [15:0] fragment_word;
      logic [7:0]  ttl;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] destination;
   } hdr_view_type;

endpackage

// ===== hdl/ipv4hrc_intf.sv =====
// ---------------------------------------------------------------------------
// ipv4hrc_intf
// Request and response channel interfaces, valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipv4hrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipv4hrc_rsp_if;
   logic                     valid;
   logic                     ready;
   ipv4hrc_pkg::verdict_type verdict;
   logic [31:0]              source_address;
   logic [31:0]              destination_address;
   logic [7:0]               protocol_number;
   logic [7:0]               time_to_live;
   logic [5:0]               payload_offset;
   logic [15:0]              payload_size;

   modport source (output valid, output verdict, output source_address,
                   output destination_address, output protocol_number,
                   output time_to_live, output payload_offset,
                   output payload_size, input ready);
   modport sink   (input valid, input verdict, input source_address,
                   input destination_address, input protocol_number,
                   input time_to_live, input payload_offset,
                   input payload_size, output ready);
endinterface

// ===== hdl/ipv4hrc_parse.sv =====
// ---------------------------------------------------------------------------
// ipv4hrc_parse
// Per-packet header state: byte counter, field capture, checksum accumulate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4hrc_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [7:0]                data_byte,
   input  logic                      last_byte,
   output ipv4hrc_pkg::hdr_view_type view
);

   ipv4hrc_pkg::hdr_view_type state_ff;
   ipv4hrc_pkg::hdr_view_type state_in;
   logic [7:0]  held_ff;
   logic [7:0]  held_in;
   logic [15:0] pos;
   logic [5:0]  hdr_len;
   logic        in_header;
   logic [16:0] sum_wide;
   logic [15:0] sum_fold;

   assign pos = state_ff.byte_count;

   // next state after this byte
   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;

      if (pos == ipv4hrc_pkg::OFS_VERSION_IHL) begin
         state_in.version      = data_byte[7:4];
         state_in.header_words = data_byte[3:0];
      end

      hdr_len   = {state_in.header_words, 2'b00};
      in_header = pos < {10'd0, hdr_len};

      // ones'-complement accumulate over header words
      sum_wide = {1'b0, state_ff.sum} + {1'b0, held_ff, data_byte};
      sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};
      if (in_header) begin
         if (!pos[0]) begin
            held_in = data_byte;
         end else begin
            state_in.sum = sum_fold;
         end
      end

      // field capture by offset
      case (pos)
         ipv4hrc_pkg::OFS_TOTAL_HI: state_in.total_length[15:8] = data_byte;
         ipv4hrc_pkg::OFS_TOTAL_LO: state_in.total_length[7:0] = data_byte;
         ipv4hrc_pkg::OFS_FRAG_HI: state_in.fragment_word[15:8] = data_byte;
         ipv4hrc_pkg::OFS_FRAG_LO: state_in.fragment_word[7:0] = data_byte;
         ipv4hrc_pkg::OFS_TTL: state_in.ttl = data_byte;
         ipv4hrc_pkg::OFS_PROTOCOL: state_in.protocol = data_byte;
         default: ;
      endcase
      if (pos inside {[ipv4hrc_pkg::OFS_SRC_FIRST:ipv4hrc_pkg::OFS_SRC_LAST]}) begin
         state_in.source = {state_ff.source[23:0], data_byte};
      end
      if (pos inside {[ipv4hrc_pkg::OFS_DST_FIRST:ipv4hrc_pkg::OFS_DST_LAST]}) begin
         state_in.destination = {state_ff.destination[23:0], data_byte};
      end

      // saturating byte counter
      if (pos != ipv4hrc_pkg::COUNT_MAX) begin
         state_in.byte_count = pos + 16'd1;
      end
   end

   assign view = state_in;

   // state registers, cleared after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         held_ff  <= '0;
      end else if (take) begin
         if (last_byte) begin
            state_ff <= '0;
            held_ff  <= '0;
         end else begin
            state_ff <= state_in;
            held_ff  <= held_in;
         end
      end
   end

endmodule

// ===== hdl/ipv4hrc_judge.sv =====
// ---------------------------------------------------------------------------
// ipv4hrc_judge
// Verdict and payload offset/length from the completed header state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4hrc_judge (
   input  ipv4hrc_pkg::hdr_view_type view,
   input  logic [31:0]               host_address,
   input  logic [31:0]               subnet_mask,
   output ipv4hrc_pkg::verdict_type  verdict,
   output logic [5:0]                payload_offset,
   output logic [15:0]               payload_size
);

   logic [15:0] hdr_len;
   logic [31:0] bcast;
   logic        malformed;
   logic        for_host;

   assign payload_offset = {view.header_words, 2'b00};
   assign hdr_len        = {10'd0, payload_offset};
   assign bcast          = host_address | ~subnet_mask;

   // length, version and checksum checks
   assign malformed = (view.byte_count < ipv4hrc_pkg::MIN_HEADER_BYTES)
                   || (view.version != ipv4hrc_pkg::IPV4_VERSION)
                   || (hdr_len < ipv4hrc_pkg::MIN_HEADER_BYTES)
                   || (hdr_len > view.byte_count)
                   || (view.total_length < hdr_len)
                   || (view.total_length > view.byte_count)
                   || (view.sum != ipv4hrc_pkg::SUM_GOOD);

   assign for_host = (view.destination == host_address)
                  || (view.destination == bcast)
                  || (view.destination == ipv4hrc_pkg::LIMITED_BCAST);

   // verdict in priority order
   always_comb begin
      if (malformed) begin
         verdict = ipv4hrc_pkg::VERDICT_MALFORMED;
      end else if ((view.fragment_word & ipv4hrc_pkg::FRAG_MASK) != 16'd0) begin
         verdict = ipv4hrc_pkg::VERDICT_FRAGMENT;
      end else if (!for_host) begin
         verdict = ipv4hrc_pkg::VERDICT_NOT_FOR_HOST;
      end else if (view.protocol == ipv4hrc_pkg::PROTO_ICMP) begin
         verdict = ipv4hrc_pkg::VERDICT_ICMP;
      end else if (view.protocol == ipv4hrc_pkg::PROTO_UDP) begin
         verdict = ipv4hrc_pkg::VERDICT_UDP;
      end else if (view.protocol == ipv4hrc_pkg::PROTO_TCP) begin
         verdict = ipv4hrc_pkg::VERDICT_TCP;
      end else begin
         verdict = ipv4hrc_pkg::VERDICT_PROTO_UNSUPP;
      end
   end

   // payload length, zero when total is below header length
   assign payload_size = (view.total_length >= hdr_len) ? (view.total_length - hdr_len)
                                                        : 16'd0;

endmodule

// ===== hdl/ipv4_header_receive_check.sv =====
// ---------------------------------------------------------------------------
// ipv4_header_receive_check
// Byte-stream IPv4 header validation and classification, top level.
// ---------------------------------------------------------------------------
// Takes one packet byte per request, one request per clock at full rate,
// with last_byte on the final byte. Each byte passes an input register,
// then the header state update and verdict logic, into the response
// register, which loads as the final byte advances out of the input register.
// Only final bytes produce a response, so a stalled response holds up the
// stream only when the next final byte reaches the verdict stage. The user
// must write host_address and subnet_mask through the csr port only while
// no packet is in flight; the block does not enforce it. Both reset to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipv4_header_receive_check (
   input  logic                clock,
   input  logic                reset,
   ipv4hrc_req_if.sink         req_bus,
   ipv4hrc_rsp_if.source       rsp_bus,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [31:0]         csr_write_data
);

   logic [31:0] host_ff;
   logic [31:0] mask_ff;

   logic        stage_valid_ff;
   logic        stage_valid_in;
   logic [7:0]  stage_byte_ff;
   logic        stage_last_ff;
   logic        advance;

   logic        out_valid_ff;
   logic        out_valid_in;

   ipv4hrc_pkg::hdr_view_type view;
   ipv4hrc_pkg::verdict_type  verdict;
   logic [5:0]                payload_offset;
   logic [15:0]               payload_size;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         host_ff <= '0;
         mask_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ipv4hrc_pkg::CSR_HOST_ADDRESS: host_ff <= csr_write_data;
            ipv4hrc_pkg::CSR_SUBNET_MASK: mask_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage advances unless a final byte meets a held response
   assign advance = stage_valid_ff && (!stage_last_ff || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stage_valid_ff || advance;
   assign stage_valid_in = (req_bus.valid && req_bus.ready) ? 1'b1
                         : (advance ? 1'b0 : stage_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         stage_byte_ff <= req_bus.data_byte;
         stage_last_ff <= req_bus.last_byte;
      end
   end

   // header state and checks
   ipv4hrc_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .take      (advance),
      .data_byte (stage_byte_ff),
      .last_byte (stage_last_ff),
      .view      (view)
   );

   ipv4hrc_judge u_judge (
      .view           (view),
      .host_address   (host_ff),
      .subnet_mask    (mask_ff),
      .verdict        (verdict),
      .payload_offset (payload_offset),
      .payload_size   (payload_size)
   );

   // response register
   assign out_valid_in = (advance && stage_last_ff) ? 1'b1
                       : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_last_ff) begin
         rsp_bus.verdict             <= verdict;
         rsp_bus.source_address      <= view.source;
         rsp_bus.destination_address <= view.destination;
         rsp_bus.protocol_number     <= view.protocol;
         rsp_bus.time_to_live        <= view.ttl;
         rsp_bus.payload_offset      <= payload_offset;
         rsp_bus.payload_size        <= payload_size;
      end
   end

   assign rsp_bus.valid = out_valid_ff;

   // checks
   `ASSERT_IMPLIES(a_rsp_from_final, clock, reset, $rose(out_valid_ff), $past(advance && stage_last_ff))
   `ASSERT_NEXT(a_stage_holds, clock, reset, stage_valid_ff && !advance, stage_valid_ff && $stable(stage_byte_ff))
   `ASSERT_IMPLIES(a_good_hdr_len, clock, reset, out_valid_ff && (rsp_bus.verdict != ipv4hrc_pkg::VERDICT_MALFORMED), rsp_bus.payload_offset >= 6'd20)
   `ASSERT_IMPLIES(a_icmp_proto, clock, reset, out_valid_ff && (rsp_bus.verdict == ipv4hrc_pkg::VERDICT_ICMP), rsp_bus.protocol_number == ipv4hrc_pkg::PROTO_ICMP)

endmodule
